// ===== sv/prrts_pkg.sv =====
// Shared types and codes for the priority round-robin task scheduler.
// No dependencies; imported by the scheduler top level.
`default_nettype none
package prrts_pkg;

  typedef struct packed {
    logic        action;
    logic [3:0]  task_id;
    logic [2:0]  priority_req;
    logic [31:0] now;
    logic [31:0] suspend_until;
    logic        waits_signal;
    logic        current_exited;
    logic [15:0] signal_ready;
  } sched_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] next_task;
    logic       privileged;
    logic [1:0] wait_result;
  } sched_res_t;

  localparam logic ACT_SCHEDULE = 1'b0;
  localparam logic ACT_ADD      = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_STOPPED = 2'd1;
  localparam logic [1:0] ST_NO_TASK = 2'd2;
  localparam logic [1:0] ST_IN_USE  = 2'd3;

  localparam logic [1:0] WR_NONE    = 2'd0;
  localparam logic [1:0] WR_SIGNAL  = 2'd1;
  localparam logic [1:0] WR_TIMEOUT = 2'd2;

  localparam logic REG_STOPPED    = 1'b0;
  localparam logic REG_PRIV_LEVELS = 1'b1;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_WLVL   = 8'b0000_0010,
    S_WRD    = 8'b0000_0100,
    S_WEV    = 8'b0000_1000,
    S_RUN_RD = 8'b0001_0000,
    S_RUN_EV = 8'b0010_0000,
    S_SEL    = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } sched_state_e;

  // Outcome of resolving one wait
  typedef struct packed {
    logic        rdy;
    logic [31:0] dl;
    logic        sw;
    logic [1:0]  oc;
  } wait_res_t;

  function automatic wait_res_t resolve_wait(input logic [31:0] dl, input logic sw,
                                             input logic [1:0] oc, input logic [31:0] now,
                                             input logic sig);
    wait_res_t r;
    r.rdy = 1'b1;
    r.dl  = 32'd0;
    r.sw  = 1'b0;
    r.oc  = oc;
    if (dl != 32'd0) begin
      if (dl > now) begin
        if (sw && sig) begin
          r.oc = WR_SIGNAL;
        end else begin
          r.rdy = 1'b0;
          r.dl  = dl;
          r.sw  = sw;
        end
      end else begin
        r.oc = sw ? WR_TIMEOUT : WR_NONE;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/priority_round_robin_task_scheduler.sv =====
// Top level of the priority round-robin task scheduler: sequencer, slot memories,
// queue head/tail registers and APB register block. Depends on prrts_pkg.
//
//  channel   handshake                 payload
//  request   start / busy              req_i  (sched_req_t)
//  result    done_o strobe, one cycle  res_o  (sched_res_t)
//  config    APB psel/penable/pwrite   paddr, pwdata, prdata
//
// An add and a stopped schedule are answered straight from idle. A schedule pass
// checks each of the NUM_PRIORITIES levels, then for each waiting task reads memory,
// then resolves and writes back; it may read and resolve the outgoing task, and then
// selects, with the result strobe in the cycle after. The single read port of the
// slot memories sets this order.
// Reset empties all queues and frees all slots; no clearing pass is needed.
// The receiver cannot stall: done_o is high for exactly one cycle per request.
`default_nettype none
module priority_round_robin_task_scheduler
  import prrts_pkg::*;
#(
  parameter int MAX_TASKS      = 16,
  parameter int NUM_PRIORITIES = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire sched_req_t req_i,
  output logic            done_o,
  output sched_res_t      res_o,
  input  wire logic       psel,
  input  wire logic       penable,
  input  wire logic       pwrite,
  input  wire logic [2:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int LW = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;

  // Slot memories, one read address, registered read data
  logic [LW-1:0] prio_mem [MAX_TASKS];
  logic [31:0]   dl_mem   [MAX_TASKS];
  logic          sw_mem   [MAX_TASKS];
  logic [1:0]    oc_mem   [MAX_TASKS];
  logic [IW-1:0] link_mem [MAX_TASKS];

  logic [LW-1:0] prio_rd;
  logic [31:0]   dl_rd;
  logic          sw_rd;
  logic [1:0]    oc_rd;
  logic [IW-1:0] link_rd;

  logic          rd_en, attr_we, prio_we, link_we;
  logic [IW-1:0] rd_addr, attr_waddr, link_waddr, link_wd;
  logic [LW-1:0] prio_wd;
  logic [31:0]   dl_wd;
  logic          sw_wd;
  logic [1:0]    oc_wd;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      prio_rd <= prio_mem[rd_addr];
      dl_rd   <= dl_mem[rd_addr];
      sw_rd   <= sw_mem[rd_addr];
      oc_rd   <= oc_mem[rd_addr];
      link_rd <= link_mem[rd_addr];
    end
    if (attr_we) begin
      dl_mem[attr_waddr] <= dl_wd;
      sw_mem[attr_waddr] <= sw_wd;
      oc_mem[attr_waddr] <= oc_wd;
    end
    if (prio_we) begin
      prio_mem[attr_waddr] <= prio_wd;
    end
    if (link_we) begin
      link_mem[link_waddr] <= link_wd;
    end
  end

  // Control state
  sched_state_e  state_q, state_d;
  sched_req_t    req_q, req_d;
  logic [LW-1:0] lvl_q, lvl_d;
  logic [IW-1:0] cur_q, cur_d, otail_q, otail_d;
  logic          run_v_q, run_v_d;
  logic [IW-1:0] run_id_q, run_id_d;
  logic [MAX_TASKS-1:0] in_use_q, in_use_d;
  logic [NUM_PRIORITIES-1:0] rq_v_q, rq_v_d, wq_v_q, wq_v_d;
  logic [IW-1:0] rq_h_q [NUM_PRIORITIES];
  logic [IW-1:0] rq_h_d [NUM_PRIORITIES];
  logic [IW-1:0] rq_t_q [NUM_PRIORITIES];
  logic [IW-1:0] rq_t_d [NUM_PRIORITIES];
  logic [IW-1:0] wq_h_q [NUM_PRIORITIES];
  logic [IW-1:0] wq_h_d [NUM_PRIORITIES];
  logic [IW-1:0] wq_t_q [NUM_PRIORITIES];
  logic [IW-1:0] wq_t_d [NUM_PRIORITIES];
  logic          stopped_q, stopped_d;
  logic [3:0]    priv_lv_q, priv_lv_d;
  logic          done_q, done_d;
  sched_res_t    res_q, res_d;

  // Combinational helpers
  logic          accept;
  logic          push_en, push_rdy;
  logic [LW-1:0] push_lvl;
  logic [IW-1:0] push_id;
  logic          sel_found;
  logic [LW-1:0] sel_lvl;
  logic [LW-1:0] add_lvl;
  logic [IW-1:0] add_id;
  logic          add_bad;
  logic          sig_bit;
  wait_res_t     wres;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign pready = 1'b1;
  assign done_o = done_q;
  assign res_o  = res_q;
  assign prdata = (paddr[2] == REG_STOPPED) ? {31'd0, stopped_q} : {28'd0, priv_lv_q};

  assign add_id  = IW'(req_i.task_id);
  assign add_bad = (7'(req_i.task_id) >= 7'(MAX_TASKS)) || in_use_q[add_id];
  assign add_lvl = (5'(req_i.priority_req) >= 5'(NUM_PRIORITIES)) ?
                   LW'(NUM_PRIORITIES - 1) : LW'(req_i.priority_req);

  always_comb begin
    sel_found = 1'b0;
    sel_lvl   = '0;
    for (int l = NUM_PRIORITIES - 1; l >= 0; l--) begin
      if (rq_v_q[l]) begin
        sel_found = 1'b1;
        sel_lvl   = LW'(l);
      end
    end
  end

  always_comb begin
    stopped_d = stopped_q;
    priv_lv_d = priv_lv_q;
    if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_STOPPED) begin
        stopped_d = pwdata[0];
      end else begin
        priv_lv_d = pwdata[3:0];
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    req_d    = req_q;
    lvl_d    = lvl_q;
    cur_d    = cur_q;
    otail_d  = otail_q;
    run_v_d  = run_v_q;
    run_id_d = run_id_q;
    in_use_d = in_use_q;
    rq_v_d   = rq_v_q;
    wq_v_d   = wq_v_q;
    rq_h_d   = rq_h_q;
    rq_t_d   = rq_t_q;
    wq_h_d   = wq_h_q;
    wq_t_d   = wq_t_q;
    done_d   = 1'b0;
    res_d    = res_q;

    rd_en      = 1'b0;
    rd_addr    = cur_q;
    attr_we    = 1'b0;
    prio_we    = 1'b0;
    attr_waddr = cur_q;
    prio_wd    = add_lvl;
    dl_wd      = 32'd0;
    sw_wd      = 1'b0;
    oc_wd      = WR_NONE;
    push_en    = 1'b0;
    push_rdy   = 1'b1;
    push_lvl   = lvl_q;
    push_id    = cur_q;
    sig_bit    = 1'b0;
    wres       = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d = req_i;
          res_d = '0;
          if (req_i.action == ACT_ADD) begin
            done_d = 1'b1;
            if (add_bad) begin
              res_d.status = ST_IN_USE;
            end else begin
              in_use_d[add_id] = 1'b1;
              attr_we    = 1'b1;
              prio_we    = 1'b1;
              attr_waddr = add_id;
              push_en    = 1'b1;
              push_lvl   = add_lvl;
              push_id    = add_id;
            end
          end else if (stopped_q) begin
            done_d       = 1'b1;
            res_d.status = ST_STOPPED;
          end else begin
            lvl_d   = '0;
            state_d = S_WLVL;
          end
        end
      end
      S_WLVL: begin
        if (wq_v_q[lvl_q]) begin
          cur_d          = wq_h_q[lvl_q];
          otail_d        = wq_t_q[lvl_q];
          wq_v_d[lvl_q]  = 1'b0;
          state_d        = S_WRD;
        end else if (lvl_q == LW'(NUM_PRIORITIES - 1)) begin
          state_d = S_RUN_RD;
        end else begin
          lvl_d = lvl_q + 1'b1;
        end
      end
      S_WRD: begin
        rd_en   = 1'b1;
        state_d = S_WEV;
      end
      S_WEV: begin
        sig_bit    = (32'(cur_q) < 32'd16) && req_q.signal_ready[4'(cur_q)];
        wres       = resolve_wait(dl_rd, sw_rd, oc_rd, req_q.now, sig_bit);
        attr_we    = 1'b1;
        dl_wd      = wres.dl;
        sw_wd      = wres.sw;
        oc_wd      = wres.oc;
        push_en    = 1'b1;
        push_rdy   = wres.rdy;
        if (cur_q == otail_q) begin
          if (lvl_q == LW'(NUM_PRIORITIES - 1)) begin
            state_d = S_RUN_RD;
          end else begin
            lvl_d   = lvl_q + 1'b1;
            state_d = S_WLVL;
          end
        end else begin
          cur_d   = link_rd;
          state_d = S_WRD;
        end
      end
      S_RUN_RD: begin
        if (!run_v_q) begin
          state_d = S_SEL;
        end else if (req_q.current_exited) begin
          in_use_d[run_id_q] = 1'b0;
          run_v_d = 1'b0;
          state_d = S_SEL;
        end else begin
          rd_en   = 1'b1;
          rd_addr = run_id_q;
          state_d = S_RUN_EV;
        end
      end
      S_RUN_EV: begin
        sig_bit    = (32'(run_id_q) < 32'd16) && req_q.signal_ready[4'(run_id_q)];
        wres       = resolve_wait(req_q.suspend_until, req_q.waits_signal, oc_rd,
                                  req_q.now, sig_bit);
        attr_we    = 1'b1;
        attr_waddr = run_id_q;
        dl_wd      = wres.dl;
        sw_wd      = wres.sw;
        oc_wd      = wres.oc;
        push_en    = 1'b1;
        push_rdy   = wres.rdy;
        push_lvl   = prio_rd;
        push_id    = run_id_q;
        run_v_d    = 1'b0;
        state_d    = S_SEL;
      end
      S_SEL: begin
        if (!sel_found) begin
          done_d       = 1'b1;
          res_d.status = ST_NO_TASK;
          state_d      = S_IDLE;
        end else begin
          // Pop the head; the new head comes from the link read
          run_v_d  = 1'b1;
          run_id_d = rq_h_q[sel_lvl];
          lvl_d    = sel_lvl;
          if (rq_h_q[sel_lvl] == rq_t_q[sel_lvl]) begin
            rq_v_d[sel_lvl] = 1'b0;
          end
          rd_en   = 1'b1;
          rd_addr = rq_h_q[sel_lvl];
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (rq_v_q[lvl_q]) begin
          rq_h_d[lvl_q] = link_rd;
        end
        done_d            = 1'b1;
        res_d.status      = ST_OK;
        res_d.next_task   = 4'(run_id_q);
        res_d.privileged  = (5'(lvl_q) < 5'(priv_lv_q));
        res_d.wait_result = oc_rd;
        state_d           = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Append to the tail of a ready or waiting queue
    link_we    = 1'b0;
    link_waddr = '0;
    link_wd    = push_id;
    if (push_en) begin
      if (push_rdy) begin
        if (rq_v_q[push_lvl]) begin
          link_we    = 1'b1;
          link_waddr = rq_t_q[push_lvl];
        end else begin
          rq_h_d[push_lvl] = push_id;
          rq_v_d[push_lvl] = 1'b1;
        end
        rq_t_d[push_lvl] = push_id;
      end else begin
        if (wq_v_d[push_lvl]) begin
          link_we    = 1'b1;
          link_waddr = wq_t_q[push_lvl];
        end else begin
          wq_h_d[push_lvl] = push_id;
          wq_v_d[push_lvl] = 1'b1;
        end
        wq_t_d[push_lvl] = push_id;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      run_v_q   <= 1'b0;
      in_use_q  <= '0;
      rq_v_q    <= '0;
      wq_v_q    <= '0;
      stopped_q <= 1'b0;
      priv_lv_q <= 4'd4;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      run_v_q   <= run_v_d;
      in_use_q  <= in_use_d;
      rq_v_q    <= rq_v_d;
      wq_v_q    <= wq_v_d;
      stopped_q <= stopped_d;
      priv_lv_q <= priv_lv_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    lvl_q    <= lvl_d;
    cur_q    <= cur_d;
    otail_q  <= otail_d;
    run_id_q <= run_id_d;
    rq_h_q   <= rq_h_d;
    rq_t_q   <= rq_t_d;
    wq_h_q   <= wq_h_d;
    wq_t_q   <= wq_t_d;
    res_q    <= res_d;
  end

  a_accept_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (done_o || busy))
    else $error("accepted request neither answered nor in progress");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while still busy");

  a_out_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |=> run_v_q)
    else $error("selected task not marked running");

  a_ok_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status == ST_OK && req_q.action == ACT_SCHEDULE) |-> run_v_q)
    else $error("schedule ok without a running task");

endmodule
`default_nettype wire
